FILE: rtl/core/lmd_pkg.sv
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, command codes and the digit font of the LED matrix frame store.
// ----------------------------------------------------------------------------
package lmd_pkg;

    typedef enum logic [1:0] {
        OP_SET_PIXEL  = 2'd0,
        OP_DRAW_DIGIT = 2'd1,
        OP_FILL       = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    localparam int unsigned GLYPH_W     = 5;
    localparam int unsigned GLYPH_H     = 8;
    localparam int unsigned GLYPH_COUNT = 10;

    localparam int unsigned RGB_W = 24;

    typedef logic [RGB_W-1:0] t_rgb;
    typedef logic [GLYPH_W-1:0] t_glyph_row;

    // 5x8 digits, bit 4 is the leftmost column
    localparam t_glyph_row FONT [GLYPH_COUNT][GLYPH_H] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h01, 5'h03, 5'h05, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}
    };

    function automatic t_glyph_row font_row(input logic [3:0] g, input logic [2:0] r);
        t_glyph_row row;
        row = '0;
        if (g < 4'(GLYPH_COUNT)) begin
            row = FONT[g][r];
        end
        return row;
    endfunction

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_PIXEL = 7'b0000100,
        ST_GLYPH = 7'b0001000,
        ST_FILL  = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } t_state;

endpackage

FILE: rtl/core/led_matrix_digit_framebuffer.sv
// ----------------------------------------------------------------------------
// led_matrix_digit_framebuffer
// Frame store for a serpentine RGB LED matrix with a built-in digit font.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel, one item at a time; tuser carries
//   the command (set pixel, draw digit, fill, read LED). Only a read returns
//   an item, on the m_axis channel, holding the stored 24-bit colour.
//   Commands run one at a time; all writes share the single write port:
//     set pixel   one write of the mapped LED, skipped off the matrix
//     draw digit  one font cell per cycle over the 5x8 cells, none for digits above 9
//     fill        writes the colour into all LEDS entries
//     read        one store read, then a response step that waits for m_axis
//   Reset starts a clearing pass that writes zero into all LEDS entries, one
//   per cycle; s_axis_tready stays low until the pass is done.
//   The result sits in an output register. Further commands are accepted while
//   it waits; a second read holds in its response step until m_axis_tready
//   frees the register.
// ----------------------------------------------------------------------------
module led_matrix_digit_framebuffer import lmd_pkg::*; #(
    parameter int unsigned COLS = 32,
    parameter int unsigned ROWS = 8,
    parameter int unsigned LEDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x[6:0], pos_y[11:7], glyph[15:12], rgb[39:16], read_index[47:40]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_rgb[23:0]
    output logic [23:0] m_axis_tdata
);

    localparam int unsigned AW = $clog2(LEDS);

    logic rsp_valid;
    logic rsp_ready;
    t_rgb rsp_data;

    logic r_m_valid, n_m_valid;
    t_rgb r_m_data, n_m_data;

    lmd_engine #(
        .COLS (COLS),
        .ROWS (ROWS),
        .LEDS (LEDS),
        .AW   (AW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (t_op'(s_axis_tuser)),
        .i_pos_x      (s_axis_tdata[6:0]),
        .i_pos_y      (s_axis_tdata[11:7]),
        .i_glyph      (s_axis_tdata[15:12]),
        .i_rgb        (s_axis_tdata[39:16]),
        .i_read_index (s_axis_tdata[47:40]),
        .o_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .o_rsp_data   (rsp_data)
    );

    assign rsp_ready = !r_m_valid || m_axis_tready;

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (rsp_valid && rsp_ready) begin
            n_m_valid = 1'b1;
            n_m_data  = rsp_data;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: rtl/core/lmd_store.sv
// ----------------------------------------------------------------------------
// lmd_store
// Frame memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmd_store import lmd_pkg::*; #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rgb          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_rgb          o_rdata
);

    t_rgb r_mem [DEPTH];
    t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lmd_pixel_map.sv
// ----------------------------------------------------------------------------
// lmd_pixel_map
// Maps a signed (x,y) pixel onto the serpentine LED chain and flags hits.
// ----------------------------------------------------------------------------
module lmd_pixel_map import lmd_pkg::*; #(
    parameter int unsigned COLS = 32,
    parameter int unsigned ROWS = 8,
    parameter int unsigned LEDS = 256,
    parameter int unsigned AW   = 8
) (
    input  logic [7:0]    i_px,
    input  logic [5:0]    i_py,
    output logic          o_hit,
    output logic [AW-1:0] o_addr
);

    localparam int unsigned IW = $clog2(COLS * ROWS);

    logic          ok_x;
    logic          ok_y;
    logic [5:0]    col;
    logic [3:0]    row;
    logic [IW-1:0] base;
    logic [IW-1:0] idx;

    always_comb begin
        ok_x = !i_px[7] && (i_px[6:0] < 7'(COLS));
        ok_y = !i_py[5] && (i_py[4:0] < 5'(ROWS));
        col  = i_px[5:0];
        row  = i_py[3:0];
        base = IW'(row) * IW'(COLS);
        // odd rows run right to left
        if (row[0]) begin
            idx = base + IW'(COLS - 1) - IW'(col);
        end else begin
            idx = base + IW'(col);
        end
        o_hit  = ok_x && ok_y && (32'(idx) < 32'(LEDS));
        o_addr = AW'(idx);
    end

endmodule

FILE: rtl/core/lmd_engine.sv
// ----------------------------------------------------------------------------
// lmd_engine
// Command sequencer: clear, pixel, glyph, fill and read walks over the store.
// ----------------------------------------------------------------------------
module lmd_engine import lmd_pkg::*; #(
    parameter int unsigned COLS = 32,
    parameter int unsigned ROWS = 8,
    parameter int unsigned LEDS = 256,
    parameter int unsigned AW   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  t_op           i_op,
    input  logic [6:0]    i_pos_x,
    input  logic [4:0]    i_pos_y,
    input  logic [3:0]    i_glyph,
    input  t_rgb          i_rgb,
    input  logic [7:0]    i_read_index,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output t_rgb          o_rsp_data
);

    localparam logic [AW-1:0] LAST = AW'(LEDS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_row, n_row;
    logic [2:0]    r_col, n_col;
    logic [6:0]    r_x, n_x;
    logic [4:0]    r_y, n_y;
    logic [3:0]    r_g, n_g;
    t_rgb          r_color, n_color;
    logic [7:0]    r_ri, n_ri;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_rgb          mem_wdata;
    logic          mem_re;
    t_rgb          mem_rdata;

    logic [7:0]    px;
    logic [5:0]    py;
    logic          map_hit;
    logic [AW-1:0] map_addr;
    t_glyph_row    glyph_bits;
    logic          glyph_on;
    logic          read_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_row   <= n_row;
            r_col   <= n_col;
            r_color <= n_color;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_g  <= n_g;
        r_ri <= n_ri;
    end

    lmd_pixel_map #(
        .COLS (COLS),
        .ROWS (ROWS),
        .LEDS (LEDS),
        .AW   (AW)
    ) u_map (
        .i_px   (px),
        .i_py   (py),
        .o_hit  (map_hit),
        .o_addr (map_addr)
    );

    lmd_store #(
        .DEPTH (LEDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (AW'(r_ri)),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        px         = {r_x[6], r_x} + 8'(r_col);
        py         = {r_y[4], r_y} + 6'(r_row);
        glyph_bits = font_row(r_g, r_row);
        glyph_on   = glyph_bits[3'(GLYPH_W - 1) - r_col];
        read_hit   = 32'(r_ri) < 32'(LEDS);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_x         = r_x;
        n_y         = r_y;
        n_g         = r_g;
        n_color     = r_color;
        n_ri        = r_ri;
        o_ready     = 1'b0;
        o_rsp_valid = 1'b0;
        o_rsp_data  = read_hit ? mem_rdata : '0;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = r_color;
        mem_re      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_cnt == LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_x     = i_pos_x;
                    n_y     = i_pos_y;
                    n_g     = i_glyph;
                    n_color = i_rgb;
                    n_ri    = i_read_index;
                    n_cnt   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    unique case (i_op)
                        OP_SET_PIXEL:  n_state = ST_PIXEL;
                        OP_DRAW_DIGIT: begin
                            // digits above nine draw nothing
                            if (i_glyph < 4'(GLYPH_COUNT)) begin
                                n_state = ST_GLYPH;
                            end
                        end
                        OP_FILL:       n_state = ST_FILL;
                        OP_READ:       n_state = ST_READ;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIXEL: begin
                mem_we    = map_hit;
                mem_waddr = map_addr;
                n_state   = ST_IDLE;
            end
            ST_GLYPH: begin
                mem_we    = map_hit && glyph_on;
                mem_waddr = map_addr;
                if (r_col == 3'(GLYPH_W - 1)) begin
                    n_col = '0;
                    if (r_row == 3'(GLYPH_H - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                if (r_cnt == LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_RESP;
            end
            ST_RESP: begin
                // hold the read data until the output register frees up
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/lmd_checker.sv
// ----------------------------------------------------------------------------
// lmd_checker
// Port-level checks of the LED matrix frame store, bound to the top level.
// ----------------------------------------------------------------------------
module lmd_checker import lmd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // reset starts the clearing pass, no item taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input accepted right after reset");

    // a read into an empty output register brings its result to m_axis without a stall
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (s_axis_tuser == OP_READ) && !m_axis_tvalid |-> ##3 m_axis_tvalid)
        else $error("read result missing");

    // fill holds s_axis_tready low as it starts its walk over the store
    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (s_axis_tuser == OP_FILL) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted during fill");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind led_matrix_digit_framebuffer lmd_checker u_lmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
